FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/core/crcbc_pkg.sv
package crcbc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int LEN_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam int HEADER_LEN  = 8;
  localparam int CHECKED_MIN = 12;
  localparam int SIZE_END    = 4;

  localparam logic [3:0] OFFSET_CHECKED  = 4'd8;
  localparam logic [3:0] OFFSET_FALLBACK = 4'd4;

  localparam logic [1:0] STATUS_MATCH    = 2'd0;
  localparam logic [1:0] STATUS_FALLBACK = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] raw_size;
    logic [31:0] crc_value;
    logic [3:0]  payload_offset;
    logic [31:0] payload_length;
  } result_t;

endpackage

FILE: rtl/core/crcbc_if.sv
interface crcbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] raw_size;
  logic [31:0] crc_value;
  logic [3:0]  payload_offset;
  logic [31:0] payload_length;

  modport source (output valid, output status, output raw_size, output crc_value,
                  output payload_offset, output payload_length, input ready);
  modport sink (input valid, input status, input raw_size, input crc_value,
                input payload_offset, input payload_length, output ready);
endinterface

FILE: rtl/core/crc32_blob_container_check_unit.sv
// Path: a final byte is held in the input register, its result is built combinationally
// and loads the output register once that register is free.
// Throughput: one byte per cycle; the byte-wise CRC update is combinational and
// only a final byte waits on a full result register.
// Reset (rst, synchronous, active high) empties both registers and restores the
// byte count, header words and CRC register to their start values.
module crc32_blob_container_check_unit
  import crcbc_pkg::*;
(
  input logic clk,
  input logic rst,
  crcbc_in_if.sink    bytes,
  crcbc_out_if.source results
);

  beat_t   in_beat;
  beat_t   s1_beat;
  logic    s1_valid;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res_next;
  result_t res_q;

  assign in_beat.data_byte = bytes.data_byte;
  assign in_beat.last_byte = bytes.last_byte;

  crcbc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_beat  (in_beat),
    .in_ready (bytes.ready),
    .take     (take),
    .valid    (s1_valid),
    .beat     (s1_beat)
  );

  crcbc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .valid     (s1_valid),
    .beat      (s1_beat),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res_next)
  );

  crcbc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res_next),
    .out_ready (results.ready),
    .out_free  (out_free),
    .valid     (results.valid),
    .res       (res_q)
  );

  assign results.status         = res_q.status;
  assign results.raw_size       = res_q.raw_size;
  assign results.crc_value      = res_q.crc_value;
  assign results.payload_offset = res_q.payload_offset;
  assign results.payload_length = res_q.payload_length;

endmodule

FILE: rtl/core/crcbc_in_reg.sv
module crcbc_in_reg
  import crcbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  beat_t in_beat,
  output logic  in_ready,
  input  logic  take,
  output logic  valid,
  output beat_t beat
);

  // The held beat leaves in the same cycle a new one arrives.
  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

FILE: rtl/core/crcbc_accum.sv
module crcbc_accum
  import crcbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    valid,
  input  beat_t   beat,
  input  logic    out_free,
  output logic    take,
  output logic    res_valid,
  output result_t res
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [31:0]           size_word;
  logic [31:0]           size_word_next;
  logic [31:0]           expected_crc;
  logic [31:0]           expected_crc_next;
  logic [31:0]           running_crc;
  logic [31:0]           running_crc_next;
  logic                  at_max;
  logic [COUNT_BITS-1:0] blob_len;
  logic [LEN_W-1:0]      len_ext;
  logic [LEN_W-1:0]      len_minus_hdr;
  logic [LEN_W-1:0]      len_minus_fb;
  logic [31:0]           actual_crc;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // A non-final byte never produces a result, so it need not wait for the output slot.
  assign take      = valid && (!beat.last_byte || out_free);
  assign res_valid = take && beat.last_byte;

  always_comb begin
    size_word_next    = size_word;
    expected_crc_next = expected_crc;
    running_crc_next  = running_crc;
    if (byte_count < COUNT_BITS'(SIZE_END)) begin
      size_word_next[{byte_count[1:0], 3'b000} +: 8] = beat.data_byte;
    end else if (byte_count < COUNT_BITS'(HEADER_LEN)) begin
      expected_crc_next[{byte_count[1:0], 3'b000} +: 8] = beat.data_byte;
    end else begin
      running_crc_next = crc_byte(running_crc, beat.data_byte);
    end

    at_max          = (byte_count == COUNT_MAX);
    byte_count_next = at_max ? byte_count : byte_count + COUNT_BITS'(1);
    blob_len        = byte_count_next;
    len_ext         = LEN_W'(blob_len);
    len_minus_hdr   = len_ext - LEN_W'(HEADER_LEN);
    len_minus_fb    = len_ext - LEN_W'(OFFSET_FALLBACK);
    actual_crc      = running_crc_next ^ CRC_ONES;

    // The header words are complete whenever the blob is long enough to use them.
    if (blob_len < COUNT_BITS'(HEADER_LEN)) begin
      res.status         = STATUS_SHORT;
      res.raw_size       = '0;
      res.crc_value      = '0;
      res.payload_offset = '0;
      res.payload_length = '0;
    end else if (blob_len >= COUNT_BITS'(CHECKED_MIN) && actual_crc == expected_crc) begin
      res.status         = STATUS_MATCH;
      res.raw_size       = size_word;
      res.crc_value      = actual_crc;
      res.payload_offset = OFFSET_CHECKED;
      res.payload_length = len_minus_hdr[31:0];
    end else begin
      res.status         = STATUS_FALLBACK;
      res.raw_size       = size_word;
      res.crc_value      = '0;
      res.payload_offset = OFFSET_FALLBACK;
      res.payload_length = len_minus_fb[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      byte_count   <= '0;
      size_word    <= '0;
      expected_crc <= '0;
      running_crc  <= CRC_ONES;
    end else if (take) begin
      byte_count   <= byte_count_next;
      size_word    <= size_word_next;
      expected_crc <= expected_crc_next;
      running_crc  <= running_crc_next;
    end
  end

endmodule

FILE: rtl/core/crcbc_out_reg.sv
module crcbc_out_reg
  import crcbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_free,
  output logic    valid,
  output result_t res
);

  assign out_free = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

FILE: rtl/core/crcbc_checker.sv
`include "assert_macros.svh"

module crcbc_checker
  import crcbc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] raw_size,
  input logic [31:0] crc_value,
  input logic [3:0]  payload_offset,
  input logic [31:0] payload_length
);

  `ASSERT_CLK_ALWAYS(a_reset_empties, clk, rst |=> !out_valid)

  `ASSERT_CLK(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(raw_size) && $stable(crc_value) && $stable(payload_offset) && $stable(payload_length))

  // A too-short blob carries nothing but its status.
  `ASSERT_CLK(a_short_zero, clk, rst, out_valid && status == STATUS_SHORT |-> raw_size == '0 && crc_value == '0 && payload_offset == '0 && payload_length == '0)

  `ASSERT_CLK(a_fields_by_status, clk, rst, out_valid |-> (status == STATUS_MATCH && payload_offset == OFFSET_CHECKED) || (status == STATUS_FALLBACK && payload_offset == OFFSET_FALLBACK && crc_value == '0) || status == STATUS_SHORT)

endmodule

bind crc32_blob_container_check_unit crcbc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .status         (results.status),
  .raw_size       (results.raw_size),
  .crc_value      (results.crc_value),
  .payload_offset (results.payload_offset),
  .payload_length (results.payload_length)
);
